### design/qdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types, codes and the quadrature transition table for the decoder.
// ----------------------------------------------------------------------------
package qdec_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_DETENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_LIMIT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_GAIN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_GAIN      = 3'd4;

    localparam logic [2:0] RST_STEPS_PER_DETENT = 3'd2;
    localparam logic [9:0] RST_FAST_LIMIT       = 10'd15;
    localparam logic [9:0] RST_MEDIUM_LIMIT     = 10'd30;
    localparam logic [3:0] RST_FAST_GAIN        = 4'd4;
    localparam logic [3:0] RST_MEDIUM_GAIN      = 4'd2;

    typedef struct packed {
        logic [2:0] steps_per_detent;
        logic [9:0] fast_limit_ms;
        logic [9:0] medium_limit_ms;
        logic [3:0] fast_gain;
        logic [3:0] medium_gain;
    } t_cfg;

    // standard 4x4 table, pins = {A, B}
    function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                    input logic [1:0] cur);
        logic signed [1:0] s;
        begin
            unique case ({prev, cur})
                4'b0001, 4'b0111, 4'b1000, 4'b1110: s = 2'sd1;
                4'b0010, 4'b0100, 4'b1011, 4'b1101: s = -2'sd1;
                default:                            s = 2'sd0;
            endcase
            return s;
        end
    endfunction

endpackage

### design/quadrature_decoder_accel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_accel_core
// Quadrature encoder decoder with speed-dependent detent acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: a command
//   (pin sample, read-and-clear, initialize), the A/B pin levels and a
//   millisecond timestamp. Each request produces exactly one result on the
//   output channel (o_out_valid / i_out_ready): the scaled detent step and
//   the pending delta.
//   Configuration writes use i_cfg_valid / o_cfg_ready with an index and
//   data; they are always accepted and should only be issued while idle.
//   A request passes through the input register and then the result
//   register before o_out_valid rises; a receiver stall can hold it in either.
//   Throughput is one request per cycle while the receiver does not stall:
//   an input register feeds a single pass of decode logic into a result
//   register, and the decoder state updates as each request enters it.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_in_ready then drops until the result is taken.
//   Synchronous reset clears both stages, the decoder state and loads the
//   default configuration.
// ----------------------------------------------------------------------------
module quadrature_decoder_accel_core #(
    parameter int TIME_WIDTH  = 32,
    parameter int DELTA_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_command,
    input  logic                             i_pin_a,
    input  logic                             i_pin_b,
    input  logic [TIME_WIDTH-1:0]            i_time_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [4:0]                o_step,
    output logic signed [DELTA_WIDTH-1:0]    o_delta_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qdec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import qdec_pkg::*;

    t_cfg                          s_cfg;
    logic                          r_in_valid;
    logic [1:0]                    r_in_cmd;
    logic [1:0]                    r_in_pins;
    logic [TIME_WIDTH-1:0]         r_in_time;
    logic                          r_out_valid;
    logic signed [4:0]             r_out_step;
    logic signed [DELTA_WIDTH-1:0] r_out_delta;
    logic                          s_out_load;
    logic                          s_in_load;
    logic signed [4:0]             s_step;
    logic signed [DELTA_WIDTH-1:0] s_delta;

    qdec_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (s_cfg)
    );

    qdec_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .DELTA_WIDTH (DELTA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (s_out_load),
        .i_cfg         (s_cfg),
        .i_command     (r_in_cmd),
        .i_pins        (r_in_pins),
        .i_time_ms     (r_in_time),
        .o_step        (s_step),
        .o_delta_value (s_delta)
    );

    assign s_out_load    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready    = !r_in_valid || s_out_load;
    assign s_in_load     = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_step        = r_out_step;
    assign o_delta_value = r_out_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_load) begin
            r_in_cmd  <= i_command;
            r_in_pins <= {i_pin_a, i_pin_b};
            r_in_time <= i_time_ms;
        end
        if (s_out_load) begin
            r_out_step  <= s_step;
            r_out_delta <= s_delta;
        end
    end

    a_non_sample_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_load && (r_in_cmd != CMD_SAMPLE) |=> (r_out_step == 5'sd0))
        else $error("non-sample request produced a step");

    a_double_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_load && (r_in_cmd == CMD_READ)) ##1 (s_out_load && (r_in_cmd == CMD_READ))
        |=> (r_out_delta == '0))
        else $error("second read did not return a cleared delta");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s_out_load |=> r_in_valid && $stable(r_in_time) && $stable(r_in_cmd))
        else $error("stalled input register lost its request");

    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_load |=> r_out_valid)
        else $error("request moved to output without a valid result");

endmodule

### design/qdec_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module qdec_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qdec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output qdec_pkg::t_cfg                 o_cfg
);
    import qdec_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEPS_PER_DETENT: n_cfg.steps_per_detent = i_cfg_data[2:0];
                REG_FAST_LIMIT:       n_cfg.fast_limit_ms    = i_cfg_data[9:0];
                REG_MEDIUM_LIMIT:     n_cfg.medium_limit_ms  = i_cfg_data[9:0];
                REG_FAST_GAIN:        n_cfg.fast_gain        = i_cfg_data[3:0];
                REG_MEDIUM_GAIN:      n_cfg.medium_gain      = i_cfg_data[3:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_detent <= RST_STEPS_PER_DETENT;
            r_cfg.fast_limit_ms    <= RST_FAST_LIMIT;
            r_cfg.medium_limit_ms  <= RST_MEDIUM_LIMIT;
            r_cfg.fast_gain        <= RST_FAST_GAIN;
            r_cfg.medium_gain      <= RST_MEDIUM_GAIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### design/qdec_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_datapath
// Decoder state and per-item logic: table step, detent accumulator,
// interval gain and saturating pending delta.
// ----------------------------------------------------------------------------
module qdec_datapath #(
    parameter int TIME_WIDTH  = 32,
    parameter int DELTA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  qdec_pkg::t_cfg                i_cfg,
    input  logic [1:0]                    i_command,
    input  logic [1:0]                    i_pins,
    input  logic [TIME_WIDTH-1:0]         i_time_ms,
    output logic signed [4:0]             o_step,
    output logic signed [DELTA_WIDTH-1:0] o_delta_value
);
    import qdec_pkg::*;

    localparam logic signed [DELTA_WIDTH-1:0] DELTA_MAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
    localparam logic signed [DELTA_WIDTH-1:0] DELTA_MIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};

    logic [1:0]                    r_prev_pins;
    logic [TIME_WIDTH-1:0]         r_last_time;
    logic signed [3:0]             r_accum;
    logic signed [DELTA_WIDTH-1:0] r_delta;

    logic signed [1:0]             s_raw;
    logic signed [3:0]             s_acc_sum;
    logic [3:0]                    s_mag;
    logic [2:0]                    s_need;
    logic                          s_is_sample;
    logic                          s_moved;
    logic                          s_detent;
    logic [TIME_WIDTH-1:0]         s_dt;
    logic [3:0]                    s_gain;
    logic signed [4:0]             s_gain_ext;
    logic signed [4:0]             s_step;
    logic signed [DELTA_WIDTH:0]   s_sum;
    logic signed [DELTA_WIDTH-1:0] s_sat;

    always_comb begin
        s_is_sample = (i_command == CMD_SAMPLE);
        s_raw       = quad_step(r_prev_pins, i_pins);
        s_moved     = s_is_sample && (s_raw != 2'sd0);
        s_acc_sum   = r_accum + {{2{s_raw[1]}}, s_raw};
        s_mag       = s_acc_sum[3] ? 4'(-s_acc_sum) : 4'(s_acc_sum);
        s_need      = (i_cfg.steps_per_detent == 3'd0) ? 3'd1 : i_cfg.steps_per_detent;
        s_detent    = s_moved && (s_mag >= {1'b0, s_need});

        s_dt = i_time_ms - r_last_time;
        if (s_dt < {{(TIME_WIDTH-10){1'b0}}, i_cfg.fast_limit_ms}) begin
            s_gain = i_cfg.fast_gain;
        end else if (s_dt < {{(TIME_WIDTH-10){1'b0}}, i_cfg.medium_limit_ms}) begin
            s_gain = i_cfg.medium_gain;
        end else begin
            s_gain = 4'd1;
        end
        s_gain_ext = {1'b0, s_gain};
        s_step     = s_detent ? (s_acc_sum[3] ? -s_gain_ext : s_gain_ext) : 5'sd0;

        s_sum = {r_delta[DELTA_WIDTH-1], r_delta} +
                {{(DELTA_WIDTH-4){s_step[4]}}, s_step};
        if (s_sum[DELTA_WIDTH] != s_sum[DELTA_WIDTH-1]) begin
            s_sat = s_sum[DELTA_WIDTH] ? DELTA_MIN : DELTA_MAX;
        end else begin
            s_sat = s_sum[DELTA_WIDTH-1:0];
        end
    end

    assign o_step        = s_step;
    assign o_delta_value = s_detent ? s_sat : r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= '0;
            r_last_time <= '0;
            r_accum     <= '0;
            r_delta     <= '0;
        end else if (i_en) begin
            case (i_command)
                CMD_SAMPLE: begin
                    r_prev_pins <= i_pins;
                    if (s_moved) begin
                        r_accum <= s_detent ? 4'sd0 : s_acc_sum;
                    end
                    if (s_detent) begin
                        r_last_time <= i_time_ms;
                        r_delta     <= s_sat;
                    end
                end
                CMD_READ: begin
                    r_delta <= '0;
                end
                CMD_INIT: begin
                    r_prev_pins <= i_pins;
                    r_last_time <= i_time_ms;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
